@@ design/lmlp_pkg.sv @@
// ----------------------------------------------------------------------------
// lmlp_pkg: shared types and constants of the LED matrix line plotter
// Geometry of the chip array, frame store layout and the command record
// that travels from the front end to the draw engine.
// ----------------------------------------------------------------------------
package lmlp_pkg;

   localparam int CHIP_COLS    = 16;
   localparam int CHIP_ROWS    = 8;
   localparam int COLOR_PLANES = 2;
   localparam int PANELS       = 1;

   localparam int        HDR_BITS = 10;
   localparam logic [7:0] HDR_BYTE = 8'hA0;

   localparam int N_CHIPS     = 4 * PANELS;
   localparam int PLANE_BYTES = (CHIP_COLS * CHIP_ROWS) / 8;
   localparam int CHIP_BYTES  = PLANE_BYTES * COLOR_PLANES + 2;
   localparam int SCR_W       = 2 * CHIP_COLS * PANELS;
   localparam int SCR_H       = 2 * CHIP_ROWS;
   localparam int STORE_DEPTH = N_CHIPS * CHIP_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(CHIP_BYTES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PLOT  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic signed [7:0] x0;
      logic signed [7:0] y0;
      logic signed [7:0] x1;
      logic signed [7:0] y1;
      logic [1:0]        color;
      logic [7:0]        dx;
      logic [7:0]        dy;
      logic              sx_pos;
      logic              sy_pos;
      logic              rd_ok;
      logic [ADDR_W-1:0] rd_addr;
   } cmd_type;

   typedef struct packed {
      logic       init_busy;
      logic       res_push;
      logic [7:0] res_data;
   } eng_stat_type;

endpackage

@@ design/lmlp_ram.sv @@
// ----------------------------------------------------------------------------
// lmlp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and returns
// the old contents on a same-address collision.
// ----------------------------------------------------------------------------
module lmlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ design/lmlp_front.sv @@
// ----------------------------------------------------------------------------
// lmlp_front: command decode and setup
// Classify the incoming transaction and precompute the line deltas,
// step directions and the flat read address with its range check.
// ----------------------------------------------------------------------------
module lmlp_front
   import lmlp_pkg::*;
(
   input  logic [1:0]        req_opcode,
   input  logic signed [7:0] req_start_x,
   input  logic signed [7:0] req_start_y,
   input  logic signed [7:0] req_end_x,
   input  logic signed [7:0] req_end_y,
   input  logic [1:0]        req_color,
   input  logic [1:0]        req_read_chip,
   input  logic [5:0]        req_read_addr,
   output cmd_type           cmd
);

   logic signed [8:0] x_diff;
   logic signed [8:0] y_diff;
   logic [15:0]       rd_flat;

   always_comb begin
      x_diff  = $signed({req_end_x[7], req_end_x}) - $signed({req_start_x[7], req_start_x});
      y_diff  = $signed({req_end_y[7], req_end_y}) - $signed({req_start_y[7], req_start_y});
      rd_flat = 16'(req_read_chip) * 16'(CHIP_BYTES) + 16'(req_read_addr);

      cmd.kind    = cmd_kind_type'(req_opcode);
      cmd.x0      = req_start_x;
      cmd.y0      = req_start_y;
      cmd.x1      = req_end_x;
      cmd.y1      = req_end_y;
      cmd.color   = req_color;
      cmd.dx      = x_diff[8] ? 8'(-x_diff) : x_diff[7:0];
      cmd.dy      = y_diff[8] ? 8'(-y_diff) : y_diff[7:0];
      cmd.sx_pos  = req_start_x < req_end_x;
      cmd.sy_pos  = req_start_y < req_end_y;
      // drop reads outside the store; they return zero
      cmd.rd_ok   = (32'(req_read_chip) < N_CHIPS) && (32'(req_read_addr) < CHIP_BYTES);
      cmd.rd_addr = rd_flat[ADDR_W-1:0];
   end

endmodule

@@ design/lmlp_queue.sv @@
// ----------------------------------------------------------------------------
// lmlp_queue: command queue between front end and draw engine
// Small FIFO of decoded commands so either side can stall on its own.
// ----------------------------------------------------------------------------
module lmlp_queue
   import lmlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (32'(p) == QUEUE_DEPTH - 1) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      full      = count_ff == QCNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/lmlp_engine.sv @@
// ----------------------------------------------------------------------------
// lmlp_engine: draw engine
// Carry out one command at a time against the frame store: pixel
// read-modify-write per plane, Bresenham stepping, store sweep and read.
// ----------------------------------------------------------------------------
module lmlp_engine
   import lmlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              cmd_avail,
   output logic              cmd_pop,
   input  logic              out_free,
   output eng_stat_type      stat,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]        ram_wr_data,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]        ram_rd_data
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SWEEP,
      S_PIX_RD,
      S_PIX_WR0,
      S_PIX_WR1,
      S_RD,
      S_RD_WAIT,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   cmd_kind_type       kind_ff, kind_in;
   logic signed [8:0]  x_ff, x_in;
   logic signed [8:0]  y_ff, y_in;
   logic signed [7:0]  x1_ff, x1_in;
   logic signed [7:0]  y1_ff, y1_in;
   logic [1:0]         color_ff, color_in;
   logic [7:0]         dx_ff, dx_in;
   logic [7:0]         dy_ff, dy_in;
   logic               sx_pos_ff, sx_pos_in;
   logic               sy_pos_ff, sy_pos_in;
   logic signed [10:0] err_ff, err_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;
   logic [7:0]         mask_ff, mask_in;
   logic               ok0_ff, ok0_in;
   logic               ok1_ff, ok1_in;
   logic [ADDR_W-1:0]  flat0_ff, flat0_in;
   logic [ADDR_W-1:0]  flat1_ff, flat1_in;
   logic [7:0]         res_data_ff, res_data_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [COL_W-1:0]   col_ff, col_in;

   // pixel mapping of the current point
   logic [7:0]         ux, uy, xc, yc, chip, mask;
   logic [5:0]         yb;
   logic [8:0]         bidx, a0, a1;
   logic [15:0]        base;
   logic               on_scr, chip_ok, wrap;

   // line stepping
   logic signed [11:0] e2, dx12, dy_neg12, err_sum;
   logic               step_x, step_y, at_end;

   always_comb begin
      ux      = x_ff[7:0];
      uy      = y_ff[7:0];
      on_scr  = !x_ff[8] && ({1'b0, ux} < 9'(SCR_W)) &&
                !y_ff[8] && ({1'b0, uy} < 9'(SCR_H));
      xc      = ux / 8'(CHIP_COLS);
      yc      = uy / 8'(CHIP_ROWS);
      chip    = xc + (xc & 8'hFE) + (yc << 1);
      yb      = 6'(uy % 8'(CHIP_ROWS)) + 6'(HDR_BITS);
      bidx    = 9'(ux % 8'(CHIP_COLS)) * 9'(CHIP_ROWS / 8) + 9'(yb >> 3);
      mask    = 8'h80 >> yb[2:0];
      // first plane bits near the header fold to the last bytes of the chip record
      wrap    = (bidx <= 9'd1) && (mask > 8'd2);
      a0      = wrap ? bidx + 9'(CHIP_BYTES - 2) : bidx;
      a1      = bidx + 9'(PLANE_BYTES);
      chip_ok = on_scr && (chip < 8'(N_CHIPS));
      base    = 16'(chip) * 16'(CHIP_BYTES);

      e2       = $signed({err_ff, 1'b0});
      dx12     = $signed({4'b0, dx_ff});
      dy_neg12 = -$signed({4'b0, dy_ff});
      step_x   = e2 >= dy_neg12;
      step_y   = e2 <= dx12;
      err_sum  = $signed({err_ff[10], err_ff}) + (step_x ? dy_neg12 : 12'sd0) +
                 (step_y ? dx12 : 12'sd0);
      at_end   = (x_ff == $signed({x1_ff[7], x1_ff})) && (y_ff == $signed({y1_ff[7], y1_ff}));
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      color_in    = color_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      sx_pos_in   = sx_pos_ff;
      sy_pos_in   = sy_pos_ff;
      err_in      = err_ff;
      rd_ok_in    = rd_ok_ff;
      rd_addr_in  = rd_addr_ff;
      mask_in     = mask_ff;
      ok0_in      = ok0_ff;
      ok1_in      = ok1_ff;
      flat0_in    = flat0_ff;
      flat1_in    = flat1_ff;
      res_data_in = res_data_ff;
      sweep_in    = sweep_ff;
      col_in      = col_ff;

      cmd_pop       = 1'b0;
      stat.res_push = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = sweep_ff;
      ram_wr_data   = '0;
      ram_rd_addr   = ADDR_W'(base + 16'(a0));

      unique case (state_ff)
         S_INIT, S_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = (col_ff == '0) ? HDR_BYTE : 8'h00;
            col_in      = (32'(col_ff) == CHIP_BYTES - 1) ? '0 : col_ff + 1'b1;
            sweep_in    = sweep_ff + 1'b1;
            if (32'(sweep_ff) == STORE_DEPTH - 1) begin
               sweep_in = '0;
               col_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (cmd_avail) begin
               cmd_pop     = 1'b1;
               kind_in     = cmd.kind;
               x_in        = $signed({cmd.x0[7], cmd.x0});
               y_in        = $signed({cmd.y0[7], cmd.y0});
               x1_in       = cmd.x1;
               y1_in       = cmd.y1;
               color_in    = cmd.color;
               dx_in       = cmd.dx;
               dy_in       = cmd.dy;
               sx_pos_in   = cmd.sx_pos;
               sy_pos_in   = cmd.sy_pos;
               err_in      = $signed({3'b0, cmd.dx}) - $signed({3'b0, cmd.dy});
               rd_ok_in    = cmd.rd_ok;
               rd_addr_in  = cmd.rd_addr;
               res_data_in = '0;
               unique case (cmd.kind)
                  CMD_PLOT, CMD_LINE: state_in = S_PIX_RD;
                  CMD_CLEAR:          state_in = S_SWEEP;
                  CMD_READ:           state_in = S_RD;
               endcase
            end
         end
         S_PIX_RD: begin
            // fetch the first plane byte, latch the rest of the plan
            mask_in  = mask;
            ok0_in   = chip_ok && (a0 < 9'(CHIP_BYTES));
            ok1_in   = chip_ok && (COLOR_PLANES > 1) && (a1 < 9'(CHIP_BYTES));
            flat0_in = ADDR_W'(base + 16'(a0));
            flat1_in = ADDR_W'(base + 16'(a1));
            state_in = S_PIX_WR0;
         end
         S_PIX_WR0: begin
            ram_wr_en   = ok0_ff;
            ram_wr_addr = flat0_ff;
            ram_wr_data = color_ff[0] ? (ram_rd_data | mask_ff) : (ram_rd_data & ~mask_ff);
            ram_rd_addr = flat1_ff;
            state_in    = S_PIX_WR1;
         end
         S_PIX_WR1: begin
            ram_wr_en   = ok1_ff;
            ram_wr_addr = flat1_ff;
            ram_wr_data = color_ff[1] ? (ram_rd_data | mask_ff) : (ram_rd_data & ~mask_ff);
            if ((kind_ff == CMD_LINE) && !at_end) begin
               err_in   = err_sum[10:0];
               if (step_x) begin
                  x_in = x_ff + (sx_pos_ff ? 9'sd1 : -9'sd1);
               end
               if (step_y) begin
                  y_in = y_ff + (sy_pos_ff ? 9'sd1 : -9'sd1);
               end
               state_in = S_PIX_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            ram_rd_addr = rd_addr_ff;
            state_in    = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            res_data_in = rd_ok_ff ? ram_rd_data : 8'h00;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               stat.res_push = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      stat.init_busy = state_ff == S_INIT;
      stat.res_data  = res_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         col_ff   <= col_in;
      end
      kind_ff     <= kind_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      color_ff    <= color_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_pos_ff   <= sx_pos_in;
      sy_pos_ff   <= sy_pos_in;
      err_ff      <= err_in;
      rd_ok_ff    <= rd_ok_in;
      rd_addr_ff  <= rd_addr_in;
      mask_ff     <= mask_in;
      ok0_ff      <= ok0_in;
      ok1_ff      <= ok1_in;
      flat0_ff    <= flat0_in;
      flat1_ff    <= flat1_in;
      res_data_ff <= res_data_in;
   end

endmodule

@@ design/led_matrix_line_plotter_core.sv @@
// ----------------------------------------------------------------------------
// led_matrix_line_plotter_core: command engine over an LED matrix frame store
// Plot, Bresenham line, clear and byte read on a 4-chip-per-panel store.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one response transaction, in
// order: read_data carries the store byte for a read and zero otherwise.
// Requests are decoded and parked in a two-entry command queue, so the
// request side keeps flowing while the draw engine works and while a
// response waits in the output register. The engine runs one command at a
// time on a single frame store RAM with one write and one registered read
// port; its cost sets the rate. A plot pops the command, fetches the first
// plane byte, writes the two planes and responds. A line repeats the fetch
// and the two plane writes for each pixel: a read-modify-write of two plane
// bytes through the single RAM. A clear sweeps every store byte,
// STORE_DEPTH (136) of them, and a read fetches one byte. After reset the
// engine runs the same sweep over all 136 bytes to load the headers;
// req_ready stays low for that time.
// ----------------------------------------------------------------------------
module led_matrix_line_plotter_core
   import lmlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic signed [7:0] req_start_x,
   input  logic signed [7:0] req_start_y,
   input  logic signed [7:0] req_end_x,
   input  logic signed [7:0] req_end_y,
   input  logic [1:0]        req_color,
   input  logic [1:0]        req_read_chip,
   input  logic [5:0]        req_read_addr,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_data
);

   cmd_type           dec_cmd;
   cmd_type           q_cmd;
   logic              q_full, q_empty, q_push, q_pop;
   eng_stat_type      eng_stat;
   logic              out_free;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_read_data_ff;

   // Front: decode the transaction into a command record.
   lmlp_front u_front (
      .req_opcode    (req_opcode),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_color     (req_color),
      .req_read_chip (req_read_chip),
      .req_read_addr (req_read_addr),
      .cmd           (dec_cmd)
   );

   // Hold off requests while the queue is full or the reset sweep runs.
   assign req_ready = !q_full && !eng_stat.init_busy;
   assign q_push    = req_valid && req_ready;

   lmlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (dec_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_cmd),
      .empty     (q_empty)
   );

   // Back: the engine owns the frame store.
   lmlp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd         (q_cmd),
      .cmd_avail   (!q_empty),
      .cmd_pop     (q_pop),
      .out_free    (out_free),
      .stat        (eng_stat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   lmlp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Output register: load a finished response when the slot is empty or
   // draining this cycle; drop valid once the consumer takes it.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_stat.res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_stat.res_push) begin
         rsp_read_data_ff <= eng_stat.res_data;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // The engine never takes a command from an empty queue.
   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   // A response is pushed only into a free output slot.
   a_push_free : assert property (@(posedge clock) disable iff (reset)
      eng_stat.res_push |-> out_free)
      else $error("response pushed over a pending response");

   // No response can be pending while the reset sweep runs.
   a_init_quiet : assert property (@(posedge clock) disable iff (reset)
      eng_stat.init_busy |-> (!rsp_valid_ff && q_empty))
      else $error("activity during store initialization");

endmodule
